FILE: hdl/agt_pkg.sv
// Package for the Adam gain tuner: fixed-point constants, reset values,
// configuration register indexes and item kinds.
// No dependencies.
`default_nettype none
package agt_pkg;

   // Adam coefficients
   localparam logic [31:0] ONE_Q31       = 32'h8000_0000;
   localparam logic [31:0] BETA1_Q31     = 32'd1932735283;
   localparam logic [31:0] BETA2_Q31     = 32'd2145336164;
   localparam logic [31:0] OM_BETA1_Q24  = 32'd1677722;
   localparam logic [31:0] OM_BETA2_Q24  = 32'd16777;

   // configuration reset values
   localparam logic [31:0] RST_LEARNING_RATE = 32'd16777;
   localparam logic [31:0] RST_GAIN_FLOOR    = 32'd839;
   localparam logic [31:0] RST_GAIN_CEILING  = 32'd176160768;
   localparam logic [31:0] RST_START_GAIN_P  = 32'd5033165;
   localparam logic [31:0] RST_START_GAIN_D  = 32'd3355443;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FLOOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CEILING  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAIN_P  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAIN_D  = 3'd4;

   // item kinds
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_TRIAL   = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/adam_gain_tuner.sv
// Adam gain tuner: a restart item or a finished trial gives its result in the cycle after
// acceptance; a trial item first updates the two bias powers, then runs, per gain, four 64-step
// divisions and a 32-step square root on the shared bit-serial divide/root unit, besides
// single-cycle steps; a zero gradient skips its division, a saturated division its iterations.
// One item is in work at a time; the next is taken in the cycle after the result goes.
// Reset (synchronous, active high) loads the default registers and the
// restart state: start gains, zero moments, bias powers at one.
// Depends on agt_pkg.
`default_nettype none
module adam_gain_tuner #(
   parameter int unsigned TRIAL_LIMIT = 100
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_kind,
   input  wire logic signed [31:0]               req_trial_error,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic        [31:0]                    rsp_gain_p,
   output logic        [31:0]                    rsp_gain_d,
   output logic        [6:0]                     rsp_trial_number,
   output logic                                  rsp_zero_step_p,
   output logic                                  rsp_zero_step_d,
   output logic                                  rsp_finished,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic   [agt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic   [31:0]                    csr_data
);

   localparam int unsigned CNT_W = $clog2(TRIAL_LIMIT + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_B1, S_B2, S_GRAD, S_DIV, S_GQ, S_GSQ, S_M1, S_M2, S_V1, S_V2,
      S_MH, S_MHD, S_VH, S_SQ, S_L1, S_L2, S_UP, S_OUT
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic [31:0] lr_ff, floor_ff, ceil_ff, start_p_ff, start_d_ff;

   // tuning state
   logic [31:0]        cur_p_ff, cur_d_ff, meas_p_ff, meas_d_ff;
   logic signed [31:0] last_err_ff;
   logic signed [47:0] m_p_ff, m_d_ff;
   logic [63:0]        v_p_ff, v_d_ff;
   logic [31:0]        b1p_ff, b2p_ff;
   logic [CNT_W-1:0]   trials_ff;

   // work registers
   logic               sel_ff, zp_ff, zd_ff, fin_ff, neg_ff, dneg_ff, vneg_ff;
   logic signed [32:0] de_ff;
   logic signed [31:0] g_ff;
   logic [63:0]        gsq_ff, mag_ff, acc_ff, mhat_ff;

   // shared divide / root unit
   logic [63:0] rem_ff, lo_ff, quo_ff, den_ff;
   logic [5:0]  cnt_ff;

   // selected gain operands
   logic [31:0]        gain_s, meas_s;
   logic signed [47:0] m_s;
   logic [63:0]        v_s;
   logic signed [32:0] dg;
   logic [32:0]        de_mag, dg_mag;
   logic [31:0]        g_abs;
   logic signed [48:0] d_diff;
   logic [47:0]        m_mag;

   // multiplier
   logic [39:0] mul_a;
   logic [31:0] mul_b;
   logic [71:0] mul_p;

   // division load
   logic        ld_go, ld_sat;
   logic [63:0] ld_hi, ld_lo, ld_den;

   // divider / root step
   logic [63:0] div_r2, sq_t;
   logic        div_ge;

   // misc datapath
   logic [63:0]        inc;
   logic signed [47:0] m_new;
   logic [63:0]        v_new;
   logic [95:0]        lr_prod;
   logic [32:0]        step;
   logic signed [34:0] ng;
   logic [31:0]        ng_clamp;
   logic [31:0]        g_sat;

   assign gain_s = sel_ff ? cur_d_ff : cur_p_ff;
   assign meas_s = sel_ff ? meas_d_ff : meas_p_ff;
   assign m_s    = sel_ff ? m_d_ff : m_p_ff;
   assign v_s    = sel_ff ? v_d_ff : v_p_ff;

   assign dg     = $signed({1'b0, gain_s}) - $signed({1'b0, meas_s});
   assign de_mag = de_ff[32] ? 33'(33'd0 - de_ff) : de_ff;
   assign dg_mag = dg[32] ? 33'(33'd0 - dg) : dg;
   assign g_abs  = g_ff[31] ? 32'(32'd0 - g_ff) : g_ff;
   assign d_diff = $signed({{9{g_ff[31]}}, g_ff, 8'd0}) - $signed({m_s[47], m_s});
   assign m_mag  = m_s[47] ? 48'(48'd0 - m_s) : m_s;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_B1:    begin mul_a = {8'd0, b1p_ff};           mul_b = agt_pkg::BETA1_Q31;    end
         S_B2:    begin mul_a = {8'd0, b2p_ff};           mul_b = agt_pkg::BETA2_Q31;    end
         S_GSQ:   begin mul_a = {8'd0, g_abs};            mul_b = g_abs;                 end
         S_M1:    begin mul_a = {15'd0, mag_ff[48:24]};   mul_b = agt_pkg::OM_BETA1_Q24; end
         S_M2:    begin mul_a = {16'd0, mag_ff[23:0]};    mul_b = agt_pkg::OM_BETA1_Q24; end
         S_V1:    begin mul_a = mag_ff[63:24];            mul_b = agt_pkg::OM_BETA2_Q24; end
         S_V2:    begin mul_a = {16'd0, mag_ff[23:0]};    mul_b = agt_pkg::OM_BETA2_Q24; end
         S_L1:    begin mul_a = {8'd0, lr_ff};            mul_b = mhat_ff[31:0];         end
         S_L2:    begin mul_a = {8'd0, lr_ff};            mul_b = mhat_ff[63:32];        end
         default: begin mul_a = '0;                       mul_b = '0;                    end
      endcase
   end

   assign mul_p = 72'(mul_a) * 72'(mul_b);

   assign inc     = acc_ff + 64'(mul_p[71:24]);
   assign m_new   = dneg_ff ? (m_s - $signed(inc[47:0])) : (m_s + $signed(inc[47:0]));
   assign v_new   = vneg_ff ? (v_s - inc) : (v_s + inc);
   assign lr_prod = {32'd0, acc_ff} + {mul_p[63:0], 32'd0};

   // operands for the shared divider: floor({hi,lo} / den)
   always_comb begin
      ld_go  = 1'b0;
      ld_hi  = '0;
      ld_lo  = '0;
      ld_den = '0;
      case (state_ff)
         S_GRAD: begin
            ld_go  = (dg != '0) && (de_ff != '0);
            ld_lo  = {7'd0, de_mag, 24'd0};
            ld_den = {31'd0, dg_mag};
         end
         S_MH: begin
            ld_go  = 1'b1;
            ld_hi  = {49'd0, m_mag[47:33]};
            ld_lo  = {m_mag[32:0], 31'd0};
            ld_den = {32'd0, 32'(agt_pkg::ONE_Q31 - b1p_ff)};
         end
         S_MHD: begin
            ld_go  = 1'b1;
            ld_hi  = {33'd0, v_s[63:33]};
            ld_lo  = {v_s[32:0], 31'd0};
            ld_den = {32'd0, 32'(agt_pkg::ONE_Q31 - b2p_ff)};
         end
         S_L2: begin
            ld_go  = 1'b1;
            ld_hi  = {32'd0, lr_prod[95:64]};
            ld_lo  = lr_prod[63:0];
            ld_den = {23'd0, 33'(quo_ff[32:0] + 33'd1), 8'd0};
         end
         default: begin
            ld_go = 1'b0;
         end
      endcase
   end

   // quotient would not fit, or zero divisor: saturate
   assign ld_sat = (ld_hi >= ld_den);

   assign div_r2 = {rem_ff[62:0], lo_ff[63]};
   assign div_ge = rem_ff[63] || (div_r2 >= den_ff);
   assign sq_t   = quo_ff + den_ff;

   always_comb begin
      if (neg_ff) begin
         g_sat = (quo_ff > 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - quo_ff[31:0]);
      end else begin
         g_sat = (quo_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   assign step = (quo_ff > 64'h1_0000_0000) ? 33'h1_0000_0000 : quo_ff[32:0];
   assign ng   = m_s[47] ? ($signed({3'd0, gain_s}) - $signed({2'd0, step}))
                         : ($signed({3'd0, gain_s}) + $signed({2'd0, step}));

   always_comb begin
      ng_clamp = ng[31:0];
      if (ng > $signed({3'd0, ceil_ff})) begin
         ng_clamp = ceil_ff;
      end
      // floor applied last so it wins over the ceiling
      if (ng > $signed({3'd0, ceil_ff}) && ceil_ff < floor_ff) begin
         ng_clamp = floor_ff;
      end else if (ng < $signed({3'd0, floor_ff})) begin
         ng_clamp = floor_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff      <= agt_pkg::RST_LEARNING_RATE;
         floor_ff   <= agt_pkg::RST_GAIN_FLOOR;
         ceil_ff    <= agt_pkg::RST_GAIN_CEILING;
         start_p_ff <= agt_pkg::RST_START_GAIN_P;
         start_d_ff <= agt_pkg::RST_START_GAIN_D;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            agt_pkg::CSR_LEARNING_RATE: lr_ff      <= csr_data;
            agt_pkg::CSR_GAIN_FLOOR:    floor_ff   <= csr_data;
            agt_pkg::CSR_GAIN_CEILING:  ceil_ff    <= csr_data;
            agt_pkg::CSR_START_GAIN_P:  start_p_ff <= csr_data;
            agt_pkg::CSR_START_GAIN_D:  start_d_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // sequencer and tuning state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         cur_p_ff    <= agt_pkg::RST_START_GAIN_P;
         cur_d_ff    <= agt_pkg::RST_START_GAIN_D;
         meas_p_ff   <= '0;
         meas_d_ff   <= '0;
         last_err_ff <= '0;
         m_p_ff      <= '0;
         m_d_ff      <= '0;
         v_p_ff      <= '0;
         v_d_ff      <= '0;
         b1p_ff      <= agt_pkg::ONE_Q31;
         b2p_ff      <= agt_pkg::ONE_Q31;
         trials_ff   <= '0;
         sel_ff      <= 1'b0;
         zp_ff       <= 1'b0;
         zd_ff       <= 1'b0;
         fin_ff      <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  zp_ff  <= 1'b0;
                  zd_ff  <= 1'b0;
                  fin_ff <= 1'b0;
                  sel_ff <= 1'b0;
                  if (req_kind == agt_pkg::KIND_RESTART) begin
                     cur_p_ff    <= start_p_ff;
                     cur_d_ff    <= start_d_ff;
                     meas_p_ff   <= '0;
                     meas_d_ff   <= '0;
                     last_err_ff <= '0;
                     m_p_ff      <= '0;
                     m_d_ff      <= '0;
                     v_p_ff      <= '0;
                     v_d_ff      <= '0;
                     b1p_ff      <= agt_pkg::ONE_Q31;
                     b2p_ff      <= agt_pkg::ONE_Q31;
                     trials_ff   <= '0;
                     state_ff    <= S_OUT;
                  end else if (trials_ff >= CNT_W'(TRIAL_LIMIT)) begin
                     fin_ff   <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     de_ff       <= $signed({req_trial_error[31], req_trial_error})
                                    - $signed({last_err_ff[31], last_err_ff});
                     last_err_ff <= req_trial_error;
                     state_ff    <= S_B1;
                  end
               end
            end
            S_B1: begin
               b1p_ff   <= mul_p[62:31];
               state_ff <= S_B2;
            end
            S_B2: begin
               b2p_ff   <= mul_p[62:31];
               state_ff <= S_GRAD;
            end
            S_GRAD: begin
               if (sel_ff) begin
                  zd_ff     <= (dg == '0);
                  meas_d_ff <= cur_d_ff;
               end else begin
                  zp_ff     <= (dg == '0);
                  meas_p_ff <= cur_p_ff;
               end
               neg_ff <= (de_ff[32] == dg[32]);
               if (ld_go) begin
                  ret_ff   <= S_GQ;
                  state_ff <= ld_sat ? S_GQ : S_DIV;
               end else begin
                  g_ff     <= '0;
                  state_ff <= S_GSQ;
               end
            end
            S_DIV: begin
               rem_ff <= div_ge ? (div_r2 - den_ff) : div_r2;
               lo_ff  <= {lo_ff[62:0], 1'b0};
               quo_ff <= {quo_ff[62:0], div_ge};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= ret_ff;
               end
            end
            S_GQ: begin
               g_ff     <= $signed(g_sat);
               state_ff <= S_GSQ;
            end
            S_GSQ: begin
               gsq_ff   <= mul_p[63:0];
               dneg_ff  <= d_diff[48];
               mag_ff   <= {15'd0, (d_diff[48] ? 49'(49'd0 - d_diff) : d_diff)};
               state_ff <= S_M1;
            end
            S_M1: begin
               acc_ff   <= mul_p[63:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               if (sel_ff) begin
                  m_d_ff <= m_new;
               end else begin
                  m_p_ff <= m_new;
               end
               vneg_ff  <= (gsq_ff < v_s);
               mag_ff   <= (gsq_ff >= v_s) ? (gsq_ff - v_s) : (v_s - gsq_ff);
               state_ff <= S_V1;
            end
            S_V1: begin
               acc_ff   <= mul_p[63:0];
               state_ff <= S_V2;
            end
            S_V2: begin
               if (sel_ff) begin
                  v_d_ff <= v_new;
               end else begin
                  v_p_ff <= v_new;
               end
               state_ff <= S_MH;
            end
            S_MH: begin
               ret_ff   <= S_MHD;
               state_ff <= ld_sat ? S_MHD : S_DIV;
            end
            S_MHD: begin
               mhat_ff  <= quo_ff;
               ret_ff   <= S_VH;
               state_ff <= ld_sat ? S_VH : S_DIV;
            end
            S_VH: begin
               // start the square root of the corrected second moment
               rem_ff   <= quo_ff;
               quo_ff   <= '0;
               den_ff   <= 64'h4000_0000_0000_0000;
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               if (rem_ff >= sq_t) begin
                  rem_ff <= rem_ff - sq_t;
                  quo_ff <= (quo_ff >> 1) + den_ff;
               end else begin
                  quo_ff <= quo_ff >> 1;
               end
               den_ff <= den_ff >> 2;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= S_L1;
               end
            end
            S_L1: begin
               acc_ff   <= mul_p[63:0];
               state_ff <= S_L2;
            end
            S_L2: begin
               ret_ff   <= S_UP;
               state_ff <= ld_sat ? S_UP : S_DIV;
            end
            S_UP: begin
               if (sel_ff) begin
                  cur_d_ff  <= ng_clamp;
                  trials_ff <= trials_ff + CNT_W'(1);
                  state_ff  <= S_OUT;
               end else begin
                  cur_p_ff <= ng_clamp;
                  sel_ff   <= 1'b1;
                  state_ff <= S_GRAD;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // load the shared divider; saturated quotients skip the iterations
         if (ld_go) begin
            rem_ff <= ld_hi;
            lo_ff  <= ld_lo;
            den_ff <= ld_den;
            cnt_ff <= '0;
            quo_ff <= ld_sat ? '1 : '0;
         end
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_gain_p       = cur_p_ff;
   assign rsp_gain_d       = cur_d_ff;
   assign rsp_trial_number = 7'(trials_ff);
   assign rsp_zero_step_p  = zp_ff;
   assign rsp_zero_step_d  = zd_ff;
   assign rsp_finished     = fin_ff;
   assign csr_ready        = 1'b1;

   a_trials_bound: assert property (@(posedge clock) disable iff (reset)
      trials_ff <= CNT_W'(TRIAL_LIMIT))
      else $error("trial count beyond limit");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   a_finished_holds_gains: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == agt_pkg::KIND_TRIAL
       && trials_ff >= CNT_W'(TRIAL_LIMIT))
      |=> ($stable(cur_p_ff) && $stable(cur_d_ff) && rsp_finished))
      else $error("finished trial changed the gains");

   a_bias_power_range: assert property (@(posedge clock) disable iff (reset)
      (b1p_ff <= agt_pkg::ONE_Q31) && (b2p_ff <= agt_pkg::ONE_Q31))
      else $error("bias power above one");

endmodule
`default_nettype wire
